@@ design/cpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfa_pkg
// Shared constants for the colored page frame allocator.
// ----------------------------------------------------------------------------
package cpfa_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_W     = 10;
  localparam int COLOR_COUNT = 16;
  localparam int COLOR_W     = 4;
  localparam int TOT_W       = 11;
  localparam int OP_W        = 4;
  localparam int STAT_W      = 3;

  localparam logic [OP_W-1:0] OP_MARK_FREE   = 4'd0;
  localparam logic [OP_W-1:0] OP_MARK_BAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_MARK_USED   = 4'd2;
  localparam logic [OP_W-1:0] OP_MARK_LOCKED = 4'd3;
  localparam logic [OP_W-1:0] OP_ALLOC       = 4'd4;
  localparam logic [OP_W-1:0] OP_FREE        = 4'd5;
  localparam logic [OP_W-1:0] OP_REF         = 4'd6;
  localparam logic [OP_W-1:0] OP_DEREF       = 4'd7;
  localparam logic [OP_W-1:0] OP_LOCK        = 4'd8;
  localparam logic [OP_W-1:0] OP_UNLOCK      = 4'd9;
  localparam logic [OP_W-1:0] OP_ZERO_STEP   = 4'd10;

  localparam logic [1:0] FS_UNCLAIMED = 2'd0;
  localparam logic [1:0] FS_USED      = 2'd1;
  localparam logic [1:0] FS_LISTED    = 2'd2;
  localparam logic [1:0] FS_BAD       = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_PAGE   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_CNT  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_COUNT = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NO_ZERO   = 3'd5;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [TOT_W-1:0]   total_t;

endpackage

@@ design/cpfa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cpfa_ram #(
  parameter int W  = 34,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/colored_page_frame_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colored_page_frame_allocator
// Page frame manager with per-color free and zeroed FIFO lists.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one request per transfer (op, page_frame,
//    page_count, preferred_color). in_stall is high while a request is in
//    work, while its result waits, and during the clearing pass.
//  - Result channel out_*: one result per request. out_valid holds with a
//    stable payload while out_stall is high; the next request is taken only
//    after the result transfer.
//  - cfg_we/cfg_wdata write page_limit; write only while idle.
//  - Steps: single-frame ops go through dispatch, state read-modify-write and
//    output; alloc and zero step through dispatch with list pop, link read
//    and output; requests rejected at dispatch go straight to output; free
//    repeats dispatch and state read-modify-write per in-range frame.
//  - One request is in work at a time; a held out_stall delays the next.
//  - Reset: rst_n low clears counters and list flags, then a clearing pass
//    over all 1024 frames zeroes the frame state memory; in_stall stays high.
// ----------------------------------------------------------------------------
module colored_page_frame_allocator #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  cpfa_pkg::total_t        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [cpfa_pkg::OP_W-1:0] in_op,
  input  cpfa_pkg::frame_t        in_page_frame,
  input  cpfa_pkg::total_t        in_page_count,
  input  cpfa_pkg::color_t        in_preferred_color,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [cpfa_pkg::STAT_W-1:0] out_status,
  output cpfa_pkg::frame_t        out_frame_out,
  output cpfa_pkg::total_t        out_pages_released,
  output cpfa_pkg::total_t        out_free_total,
  output cpfa_pkg::total_t        out_zeroed_total,
  output cpfa_pkg::total_t        out_available_total,
  output cpfa_pkg::total_t        out_used_total,
  output cpfa_pkg::total_t        out_bad_total
);
  import cpfa_pkg::*;

  localparam int FMW = 2 + 2 * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_FEX   = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [OP_W-1:0] op_r;
  frame_t frm_r;
  total_t cnt_r;
  color_t pref_r;
  total_t idx_r, idx_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  frame_t fout_r, fout_nxt;
  total_t rel_r, rel_nxt;
  logic badr_r, badr_nxt, zref_r, zref_nxt;
  logic pop_z_r, pop_z_nxt, pop_last_r, pop_last_nxt;
  color_t pop_c_r, pop_c_nxt;
  frame_t clr_r;
  total_t limit_r;
  total_t free_r, free_nxt, zero_r, zero_nxt, used_r, used_nxt, bad_r, bad_nxt;

  frame_t fhead_r [COLOR_COUNT];
  frame_t ftail_r [COLOR_COUNT];
  frame_t zhead_r [COLOR_COUNT];
  frame_t ztail_r [COLOR_COUNT];
  logic [COLOR_COUNT-1:0] fbusy_r, zbusy_r;

  // frame state memory and link memory
  logic fm_we;
  frame_t fm_waddr;
  logic [FMW-1:0] fm_wdata, fm_q;
  logic ln_we;
  frame_t ln_waddr, ln_wdata, ln_raddr, ln_q;

  logic [TOT_W:0] cur;
  total_t lim;
  logic [1:0] fs;
  logic [COUNT_WIDTH-1:0] fref, flock, ref_dec;
  logic push_en, push_z, pop_start;
  color_t push_c, pick_c, zpick_c;
  frame_t push_f, pop_f;
  logic pick_ok, zpick_ok, acc;

  assign acc = in_valid && !in_stall;
  assign cur = {2'b00, frm_r} + {1'b0, idx_r};
  assign lim = (limit_r > total_t'(FRAME_COUNT)) ? total_t'(FRAME_COUNT) : limit_r;
  assign fs = fm_q[FMW-1 -: 2];
  assign fref = fm_q[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
  assign flock = fm_q[COUNT_WIDTH-1:0];
  assign ref_dec = fref - 1'b1;

  cpfa_ram #(.W(FMW), .AW(FRAME_W)) u_fm (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(cur[FRAME_W-1:0]), .rdata(fm_q)
  );

  cpfa_ram #(.W(FRAME_W), .AW(FRAME_W)) u_link (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_q)
  );

  // color scan: preferred color first, then lowest busy color
  always_comb begin
    pick_ok = 1'b0;
    pick_c = pref_r;
    zpick_ok = 1'b0;
    zpick_c = '0;
    if (zbusy_r[pref_r] || fbusy_r[pref_r]) begin
      pick_ok = 1'b1;
    end else begin
      for (int i = COLOR_COUNT - 1; i >= 0; i--) begin
        if (zbusy_r[i] || fbusy_r[i]) begin
          pick_ok = 1'b1;
          pick_c = color_t'(i);
        end
      end
    end
    for (int i = COLOR_COUNT - 1; i >= 0; i--) begin
      if (fbusy_r[i]) begin
        zpick_ok = 1'b1;
        zpick_c = color_t'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    stat_nxt = stat_r;
    fout_nxt = fout_r;
    rel_nxt = rel_r;
    badr_nxt = badr_r;
    zref_nxt = zref_r;
    pop_z_nxt = pop_z_r;
    pop_c_nxt = pop_c_r;
    pop_last_nxt = pop_last_r;
    free_nxt = free_r;
    zero_nxt = zero_r;
    used_nxt = used_r;
    bad_nxt = bad_r;
    fm_we = 1'b0;
    fm_waddr = cur[FRAME_W-1:0];
    fm_wdata = '0;
    push_en = 1'b0;
    push_z = 1'b0;
    push_c = cur[COLOR_W-1:0];
    push_f = cur[FRAME_W-1:0];
    pop_start = 1'b0;
    pop_f = '0;
    ln_raddr = '0;

    case (st_r)
      S_CLEAR: begin
        fm_we = 1'b1;
        fm_waddr = clr_r;
        if (clr_r == frame_t'(FRAME_COUNT - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          st_nxt = S_DISP;
          idx_nxt = '0;
          stat_nxt = STAT_OK;
          fout_nxt = '0;
          rel_nxt = '0;
          badr_nxt = 1'b0;
          zref_nxt = 1'b0;
        end
      end
      S_DISP: begin
        case (op_r)
          OP_ALLOC: begin
            if (cnt_r == '0) begin
              stat_nxt = STAT_BAD_COUNT;
              st_nxt = S_OUT;
            end else if ({1'b0, cnt_r} > ({1'b0, free_r} + {1'b0, zero_r})) begin
              stat_nxt = STAT_NO_PAGE;
              st_nxt = S_OUT;
            end else if (cnt_r != total_t'(1)) begin
              stat_nxt = STAT_BAD_COUNT;
              st_nxt = S_OUT;
            end else if (!pick_ok) begin
              stat_nxt = STAT_NO_PAGE;
              st_nxt = S_OUT;
            end else begin
              // pop zeroed before free, mark page used
              pop_start = 1'b1;
              pop_z_nxt = zbusy_r[pick_c];
              pop_c_nxt = pick_c;
              if (zbusy_r[pick_c]) begin
                pop_f = zhead_r[pick_c];
                pop_last_nxt = (zhead_r[pick_c] == ztail_r[pick_c]);
                zero_nxt = zero_r - 1'b1;
              end else begin
                pop_f = fhead_r[pick_c];
                pop_last_nxt = (fhead_r[pick_c] == ftail_r[pick_c]);
                free_nxt = free_r - 1'b1;
              end
              ln_raddr = pop_f;
              used_nxt = used_r + 1'b1;
              fm_we = 1'b1;
              fm_waddr = pop_f;
              fm_wdata = {FS_USED, COUNT_WIDTH'(1), {COUNT_WIDTH{1'b0}}};
              fout_nxt = pop_f;
              st_nxt = S_POP;
            end
          end
          OP_ZERO_STEP: begin
            if (!zpick_ok) begin
              stat_nxt = STAT_NO_ZERO;
              st_nxt = S_OUT;
            end else begin
              // move head of free list to the tail of the zeroed list
              pop_start = 1'b1;
              pop_z_nxt = 1'b0;
              pop_c_nxt = zpick_c;
              pop_f = fhead_r[zpick_c];
              pop_last_nxt = (fhead_r[zpick_c] == ftail_r[zpick_c]);
              ln_raddr = pop_f;
              push_en = 1'b1;
              push_z = 1'b1;
              push_c = zpick_c;
              push_f = pop_f;
              free_nxt = free_r - 1'b1;
              zero_nxt = zero_r + 1'b1;
              fout_nxt = pop_f;
              st_nxt = S_POP;
            end
          end
          OP_FREE: begin
            if (idx_r == cnt_r) begin
              stat_nxt = badr_r ? STAT_RANGE : (zref_r ? STAT_ZERO_CNT : STAT_OK);
              st_nxt = S_OUT;
            end else if (cur >= {1'b0, lim}) begin
              badr_nxt = 1'b1;
              idx_nxt = idx_r + 1'b1;
            end else begin
              st_nxt = S_FEX;
            end
          end
          OP_MARK_FREE, OP_MARK_BAD, OP_MARK_USED, OP_MARK_LOCKED,
          OP_REF, OP_DEREF, OP_LOCK, OP_UNLOCK: begin
            if ({1'b0, frm_r} >= lim) begin
              stat_nxt = STAT_RANGE;
              st_nxt = S_OUT;
            end else begin
              st_nxt = S_FEX;
            end
          end
          default: begin
            st_nxt = S_OUT;
          end
        endcase
      end
      S_FEX: begin
        st_nxt = S_OUT;
        case (op_r)
          OP_MARK_FREE, OP_MARK_BAD, OP_MARK_USED, OP_MARK_LOCKED: begin
            if (fs == FS_LISTED) begin
              stat_nxt = STAT_NO_PAGE;
            end else begin
              if (fs == FS_USED) begin
                used_nxt = used_r - 1'b1;
              end
              if (fs == FS_BAD) begin
                bad_nxt = bad_r - 1'b1;
              end
              fm_we = 1'b1;
              if (op_r == OP_MARK_FREE) begin
                fm_wdata = {FS_LISTED, {2*COUNT_WIDTH{1'b0}}};
                push_en = 1'b1;
                free_nxt = free_r + 1'b1;
                rel_nxt = total_t'(1);
              end else if (op_r == OP_MARK_BAD) begin
                fm_wdata = {FS_BAD, {2*COUNT_WIDTH{1'b0}}};
                if (fs == FS_BAD) begin
                  bad_nxt = bad_r;
                end else begin
                  bad_nxt = bad_r + 1'b1;
                end
              end else begin
                fm_wdata = {FS_USED, COUNT_WIDTH'(1),
                            COUNT_WIDTH'(op_r == OP_MARK_LOCKED)};
                if (fs == FS_USED) begin
                  used_nxt = used_r;
                end else begin
                  used_nxt = used_r + 1'b1;
                end
              end
            end
          end
          OP_DEREF, OP_FREE: begin
            if (op_r == OP_FREE) begin
              idx_nxt = idx_r + 1'b1;
              st_nxt = S_DISP;
            end
            if (fs != FS_USED || fref == '0) begin
              stat_nxt = (op_r == OP_DEREF) ? STAT_ZERO_CNT : stat_r;
              zref_nxt = 1'b1;
            end else begin
              fm_we = 1'b1;
              if (ref_dec == '0 && flock == '0) begin
                // last reference gone and no lock held: back on the free list
                fm_wdata = {FS_LISTED, {2*COUNT_WIDTH{1'b0}}};
                push_en = 1'b1;
                used_nxt = used_r - 1'b1;
                free_nxt = free_r + 1'b1;
                rel_nxt = rel_r + 1'b1;
              end else begin
                fm_wdata = {FS_USED, ref_dec, flock};
              end
            end
          end
          default: begin
            // ref, lock, unlock
            if (fs != FS_USED) begin
              stat_nxt = STAT_NO_PAGE;
            end else if (op_r == OP_REF) begin
              fm_we = 1'b1;
              fm_wdata = {FS_USED, (fref == CNT_MAX) ? fref : fref + 1'b1, flock};
            end else if (op_r == OP_LOCK) begin
              fm_we = 1'b1;
              fm_wdata = {FS_USED, fref, (flock == CNT_MAX) ? flock : flock + 1'b1};
            end else if (flock != '0) begin
              fm_we = 1'b1;
              fm_wdata = {FS_USED, fref, flock - 1'b1};
            end else begin
              stat_nxt = STAT_ZERO_CNT;
            end
          end
        endcase
      end
      S_POP: begin
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // link write: append behind the current tail when the list is nonempty
  always_comb begin
    ln_we = 1'b0;
    ln_waddr = push_z ? ztail_r[push_c] : ftail_r[push_c];
    ln_wdata = push_f;
    if (push_en) begin
      ln_we = push_z ? zbusy_r[push_c] : fbusy_r[push_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      limit_r <= total_t'(FRAME_COUNT);
      free_r <= '0;
      zero_r <= '0;
      used_r <= '0;
      bad_r <= '0;
      fbusy_r <= '0;
      zbusy_r <= '0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      free_r <= free_nxt;
      zero_r <= zero_nxt;
      used_r <= used_nxt;
      bad_r <= bad_nxt;
      if (pop_start && pop_last_nxt) begin
        if (pop_z_nxt) begin
          zbusy_r[pop_c_nxt] <= 1'b0;
        end else begin
          fbusy_r[pop_c_nxt] <= 1'b0;
        end
      end
      if (push_en) begin
        if (push_z) begin
          zbusy_r[push_c] <= 1'b1;
        end else begin
          fbusy_r[push_c] <= 1'b1;
        end
      end
    end
  end

  // list ends, request payload and result state, no reset needed
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= in_op;
      frm_r <= in_page_frame;
      cnt_r <= in_page_count;
      pref_r <= in_preferred_color;
    end
    idx_r <= idx_nxt;
    stat_r <= stat_nxt;
    fout_r <= fout_nxt;
    rel_r <= rel_nxt;
    badr_r <= badr_nxt;
    zref_r <= zref_nxt;
    pop_z_r <= pop_z_nxt;
    pop_c_r <= pop_c_nxt;
    pop_last_r <= pop_last_nxt;
    if (push_en) begin
      if (push_z) begin
        if (!zbusy_r[push_c]) begin
          zhead_r[push_c] <= push_f;
        end
        ztail_r[push_c] <= push_f;
      end else begin
        if (!fbusy_r[push_c]) begin
          fhead_r[push_c] <= push_f;
        end
        ftail_r[push_c] <= push_f;
      end
    end
    // advance head to the successor read from the link memory
    if (st_r == S_POP && !pop_last_r) begin
      if (pop_z_r) begin
        zhead_r[pop_c_r] <= ln_q;
      end else begin
        fhead_r[pop_c_r] <= ln_q;
      end
    end
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_status = stat_r;
  assign out_frame_out = fout_r;
  assign out_pages_released = rel_r;
  assign out_free_total = free_r;
  assign out_zeroed_total = zero_r;
  assign out_available_total = free_r + zero_r;
  assign out_used_total = used_r;
  assign out_bad_total = bad_r;

`ifndef SYNTHESIS
  a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_r} + {1'b0, zero_r}) <= (TOT_W+1)'(FRAME_COUNT))
    else $error("available pages exceed frame count");
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == '0) |-> (fbusy_r == '0))
    else $error("free list flagged with zero free pages");
  a_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (zero_r == '0) |-> (zbusy_r == '0))
    else $error("zeroed list flagged with zero zeroed pages");
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !out_valid)
    else $error("result shown in the cycle after a transfer");
`endif
endmodule
